/* hdl/mpps_pkg.sv */
package mpps_pkg;

  localparam int DefPorts     = 4;
  localparam int DefTimeBits  = 16;
  localparam int DefCountBits = 8;

  // fixed field widths of the stream payload
  localparam int FuncW     = 2;
  localparam int PortW     = 2;
  localparam int TimeInW   = 16;
  localparam int CountInW  = 8;
  localparam int MaskW     = 4;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 24;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_PULSE   = 2'd1,
    FUNC_PATTERN = 2'd2,
    FUNC_STOP    = 2'd3
  } func_t;

  // per-port request, already qualified by the pipeline advance
  typedef struct packed {
    logic tick;
    logic pulse;
    logic pattern;
    logic stop;
    logic hard;
  } port_req_t;

  // per-port status and motor commands for the current transaction
  typedef struct packed {
    logic running;
    logic start;
    logic soft_stop;
    logic hard_halt;
  } port_cmd_t;

endpackage

/* hdl/mpps_port.sv */
module mpps_port
  import mpps_pkg::*;
#(
  parameter int TIME_BITS  = DefTimeBits,
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  port_req_t             req,
  input  logic [TIME_BITS-1:0]  on_time,
  input  logic [TIME_BITS-1:0]  off_time,
  input  logic [COUNT_BITS-1:0] pulse_count,
  output port_cmd_t             cmd
);

  logic                  active, active_next;
  logic                  on_stage, on_stage_next;
  logic                  running, running_next;
  logic                  hard_end, hard_end_next;
  logic [TIME_BITS-1:0]  phase_left, phase_left_next, phase_dec;
  logic [TIME_BITS-1:0]  on_len, on_len_next;
  logic [TIME_BITS-1:0]  off_len, off_len_next;
  logic [COUNT_BITS-1:0] pulses_rem, pulses_rem_next, pulses_dec;
  logic                  start_cmd, soft_cmd, hard_cmd;

  assign phase_dec  = (phase_left != '0) ? phase_left - TIME_BITS'(1) : phase_left;
  assign pulses_dec = (pulses_rem != '0) ? pulses_rem - COUNT_BITS'(1) : pulses_rem;

  always_comb begin
    active_next     = active;
    on_stage_next   = on_stage;
    running_next    = running;
    hard_end_next   = hard_end;
    phase_left_next = phase_left;
    on_len_next     = on_len;
    off_len_next    = off_len;
    pulses_rem_next = pulses_rem;
    start_cmd       = 1'b0;
    soft_cmd        = 1'b0;
    hard_cmd        = 1'b0;

    if (req.tick && active) begin
      if (phase_dec != '0) begin
        phase_left_next = phase_dec;
      end else if (on_stage) begin
        if (pulses_dec == '0) begin
          // last on phase done: end of train
          active_next     = 1'b0;
          on_stage_next   = 1'b0;
          pulses_rem_next = '0;
          phase_left_next = phase_dec;
          if (running) begin
            running_next = 1'b0;
            hard_cmd     = hard_end;
            soft_cmd     = !hard_end;
          end
        end else begin
          pulses_rem_next = pulses_dec;
          if (off_len != '0) begin
            on_stage_next   = 1'b0;
            phase_left_next = off_len;
            if (running) begin
              running_next = 1'b0;
              soft_cmd     = 1'b1;
            end
          end else begin
            phase_left_next = on_len;
          end
        end
      end else begin
        on_stage_next   = 1'b1;
        phase_left_next = on_len;
        if (!running) begin
          running_next = 1'b1;
          start_cmd    = 1'b1;
        end
      end
    end

    if (req.pulse && active && on_stage && pulses_rem == COUNT_BITS'(1) &&
        off_len == '0) begin
      // extend a running continuous pulse
      if (on_time > phase_left) phase_left_next = on_time;
      if (!running) begin
        running_next = 1'b1;
        start_cmd    = 1'b1;
      end
    end else if (req.pulse || req.pattern) begin
      on_len_next     = on_time;
      off_len_next    = req.pattern ? off_time : '0;
      pulses_rem_next = req.pattern ? pulse_count : COUNT_BITS'(1);
      hard_end_next   = req.pattern ? req.hard : 1'b1;
      active_next     = 1'b1;
      on_stage_next   = 1'b1;
      phase_left_next = on_time;
      if (!running) begin
        running_next = 1'b1;
        start_cmd    = 1'b1;
      end
    end

    if (req.stop) begin
      active_next     = 1'b0;
      on_stage_next   = 1'b0;
      pulses_rem_next = '0;
      if (running) begin
        running_next = 1'b0;
        hard_cmd     = req.hard;
        soft_cmd     = !req.hard;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      on_stage <= 1'b0;
      running  <= 1'b0;
      hard_end <= 1'b0;
    end else begin
      active   <= active_next;
      on_stage <= on_stage_next;
      running  <= running_next;
      hard_end <= hard_end_next;
    end
    phase_left <= phase_left_next;
    on_len     <= on_len_next;
    off_len    <= off_len_next;
    pulses_rem <= pulses_rem_next;
  end

  assign cmd.running   = running_next;
  assign cmd.start     = start_cmd;
  assign cmd.soft_stop = soft_cmd;
  assign cmd.hard_halt = hard_cmd;

endmodule

/* hdl/multi_port_pulse_pattern_sequencer.sv */
// a transaction passes through the input register, then the result register
// throughput: one transaction per cycle unless the result side stalls; each input gives exactly one result
// all ports update in parallel in the cycle the input register moves to the result register
// reset (rst, synchronous) stops all trains, clears motor state and empties both registers
module multi_port_pulse_pattern_sequencer
  import mpps_pkg::*;
#(
  parameter int PORTS      = DefPorts,
  parameter int TIME_BITS  = DefTimeBits,
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,  // port, on_time, off_time, pulse_count, hard
  input  logic [FuncW-1:0]    s_tuser,  // func
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata   // accepted, motor_on_mask, start_mask,
                                        // soft_stop_mask, hard_stop_mask
);

  localparam logic [31:0] TimeMax  = 32'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_BITS) - 64'd1);

  // input register
  logic                in_valid;
  func_t               in_func;
  logic [PortW-1:0]    in_port;
  logic [TimeInW-1:0]  in_on;
  logic [TimeInW-1:0]  in_off;
  logic [CountInW-1:0] in_count;
  logic                in_hard;

  logic advance;
  logic [31:0] on_ext, off_ext, count_ext;
  logic [TIME_BITS-1:0]  on_sat, off_sat;
  logic [COUNT_BITS-1:0] count_sat;
  logic port_ok, accepted;

  port_cmd_t cmd [PORTS];
  logic [MaskW-1:0] run_mask, start_mask, soft_mask, hard_mask;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_func  <= func_t'(s_tuser);
      in_port  <= s_tdata[1:0];
      in_on    <= s_tdata[17:2];
      in_off   <= s_tdata[33:18];
      in_count <= s_tdata[41:34];
      in_hard  <= s_tdata[42];
    end
  end

  // saturate to the configured counter widths
  assign on_ext    = 32'(in_on);
  assign off_ext   = 32'(in_off);
  assign count_ext = 32'(in_count);
  assign on_sat    = (on_ext > TimeMax) ? '1 : on_ext[TIME_BITS-1:0];
  assign off_sat   = (off_ext > TimeMax) ? '1 : off_ext[TIME_BITS-1:0];
  assign count_sat = (count_ext > CountMax) ? '1 : count_ext[COUNT_BITS-1:0];

  assign port_ok = 32'(in_port) < 32'(PORTS);

  always_comb begin
    case (in_func)
      FUNC_TICK:    accepted = 1'b1;
      FUNC_PULSE:   accepted = port_ok && (in_on != '0);
      FUNC_PATTERN: accepted = port_ok && (in_on != '0) && (in_count != '0);
      FUNC_STOP:    accepted = port_ok;
      default:      accepted = 1'b0;
    endcase
  end

  for (genvar p = 0; p < PORTS; p++) begin : g_port
    port_req_t req;
    logic      sel;

    assign sel         = advance && accepted && (32'(in_port) == 32'(p));
    assign req.tick    = advance && (in_func == FUNC_TICK);
    assign req.pulse   = sel && (in_func == FUNC_PULSE);
    assign req.pattern = sel && (in_func == FUNC_PATTERN);
    assign req.stop    = sel && (in_func == FUNC_STOP);
    assign req.hard    = in_hard;

    mpps_port #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_port (
      .clk         (clk),
      .rst         (rst),
      .req         (req),
      .on_time     (on_sat),
      .off_time    (off_sat),
      .pulse_count (count_sat),
      .cmd         (cmd[p])
    );
  end

  // only the first four ports show in the masks
  for (genvar b = 0; b < MaskW; b++) begin : g_mask
    if (b < PORTS) begin : g_on
      assign run_mask[b]   = cmd[b].running;
      assign start_mask[b] = cmd[b].start;
      assign soft_mask[b]  = cmd[b].soft_stop;
      assign hard_mask[b]  = cmd[b].hard_halt;
    end else begin : g_off
      assign run_mask[b]   = 1'b0;
      assign start_mask[b] = 1'b0;
      assign soft_mask[b]  = 1'b0;
      assign hard_mask[b]  = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {7'd0, hard_mask, soft_mask, start_mask, run_mask, accepted};
    end
  end

endmodule

/* dv/multi_port_pulse_pattern_sequencer_tb.sv */
module multi_port_pulse_pattern_sequencer_tb;
  import mpps_pkg::*;

  localparam int NumPorts   = DefPorts;
  localparam int TimeBits   = DefTimeBits;
  localparam int CountBits  = DefCountBits;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 8;

  typedef struct packed {
    func_t                func;
    logic [PortW-1:0]     port;
    logic [TimeBits-1:0]  on_t;
    logic [TimeBits-1:0]  off_t;
    logic [CountBits-1:0] count;
    logic                 hard;
  } motor_req_t;

  typedef struct packed {
    logic             accepted;
    logic [MaskW-1:0] running;
    logic [MaskW-1:0] start;
    logic [MaskW-1:0] soft_stop;
    logic [MaskW-1:0] hard_halt;
  } motor_status_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [FuncW-1:0]    s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  multi_port_pulse_pattern_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // per-port train state of the motor model
  logic                 train_active [NumPorts];
  logic                 on_stage     [NumPorts];
  logic                 motor_run    [NumPorts];
  logic                 hard_at_end  [NumPorts];
  logic [TimeBits-1:0]  phase_left   [NumPorts];
  logic [TimeBits-1:0]  on_len       [NumPorts];
  logic [TimeBits-1:0]  off_len      [NumPorts];
  logic [CountBits-1:0] pulses_rem   [NumPorts];
  logic [MaskW-1:0]     start_cmds;
  logic [MaskW-1:0]     soft_cmds;
  logic [MaskW-1:0]     hard_cmds;

  motor_status_t expected_status[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            hold_len    = 0;
  bit            calm        = 0;
  bit            steady      = 0;

  function automatic void motor_set(int p, logic turn_on, logic hard);
    if (turn_on) begin
      if (!motor_run[p]) begin
        motor_run[p]  = 1'b1;
        start_cmds[p] = 1'b1;
      end
    end else if (motor_run[p]) begin
      motor_run[p] = 1'b0;
      if (hard) hard_cmds[p] = 1'b1;
      else soft_cmds[p] = 1'b1;
    end
  endfunction

  function automatic void halt_train(int p, logic hard);
    train_active[p] = 1'b0;
    on_stage[p]     = 1'b0;
    pulses_rem[p]   = '0;
    motor_set(p, 1'b0, hard);
  endfunction

  function automatic void advance_port(int p);
    if (!train_active[p]) return;
    if (phase_left[p] != 0) phase_left[p] = phase_left[p] - 1'b1;
    if (phase_left[p] != 0) return;
    if (on_stage[p]) begin
      if (pulses_rem[p] != 0) pulses_rem[p] = pulses_rem[p] - 1'b1;
      if (pulses_rem[p] == 0) begin
        halt_train(p, hard_at_end[p]);
      end else if (off_len[p] != 0) begin
        motor_set(p, 1'b0, 1'b0);
        on_stage[p]   = 1'b0;
        phase_left[p] = off_len[p];
      end else begin
        phase_left[p] = on_len[p];
      end
    end else begin
      motor_set(p, 1'b1, 1'b0);
      on_stage[p]   = 1'b1;
      phase_left[p] = on_len[p];
    end
  endfunction

  function automatic void launch_train(int p, logic [TimeBits-1:0] on_t,
                                       logic [TimeBits-1:0] off_t,
                                       logic [CountBits-1:0] cnt, logic hard);
    on_len[p]       = on_t;
    off_len[p]      = off_t;
    pulses_rem[p]   = cnt;
    hard_at_end[p]  = hard;
    train_active[p] = 1'b1;
    on_stage[p]     = 1'b1;
    phase_left[p]   = on_t;
    motor_set(p, 1'b1, 1'b0);
  endfunction

  function automatic motor_status_t motor_step(motor_req_t r);
    motor_status_t s;
    int            p;
    s          = '0;
    start_cmds = '0;
    soft_cmds  = '0;
    hard_cmds  = '0;
    p          = int'(r.port);
    case (r.func)
      FUNC_TICK: begin
        for (int i = 0; i < NumPorts; i++) advance_port(i);
        s.accepted = 1'b1;
      end
      FUNC_PULSE: begin
        if (r.on_t != 0) begin
          s.accepted = 1'b1;
          // a running single continuous pulse is stretched, not restarted
          if (train_active[p] && on_stage[p] && pulses_rem[p] == 1 && off_len[p] == 0)
          begin
            if (r.on_t > phase_left[p]) phase_left[p] = r.on_t;
            motor_set(p, 1'b1, 1'b0);
          end else begin
            launch_train(p, r.on_t, '0, CountBits'(1), 1'b1);
          end
        end
      end
      FUNC_PATTERN: begin
        if (r.on_t != 0 && r.count != 0) begin
          s.accepted = 1'b1;
          launch_train(p, r.on_t, r.off_t, r.count, r.hard);
        end
      end
      default: begin
        s.accepted = 1'b1;
        halt_train(p, r.hard);
      end
    endcase
    for (int i = 0; i < NumPorts; i++) s.running[i] = motor_run[i];
    s.start     = start_cmds;
    s.soft_stop = soft_cmds;
    s.hard_halt = hard_cmds;
    return s;
  endfunction

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input func_t f, input int p, input int on_t, input int off_t,
                           input int cnt, input int hd);
    motor_req_t r;
    int         gap;
    r = '{func: f, port: PortW'(p), on_t: TimeBits'(on_t), off_t: TimeBits'(off_t),
          count: CountBits'(cnt), hard: 1'(hd)};
    expected_status.push_back(motor_step(r));
    if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {5'b0, r.hard, r.count, r.off_t, r.on_t, r.port};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, $urandom_range(0, 3), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    motor_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_status.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_tdata);
        error_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("accepted", want.accepted, m_tdata[0]);
        check_field("motor_on_mask", want.running, m_tdata[4:1]);
        check_field("start_mask", want.start, m_tdata[8:5]);
        check_field("soft_stop_mask", want.soft_stop, m_tdata[12:9]);
        check_field("hard_stop_mask", want.hard_halt, m_tdata[16:13]);
      end
    end
  end

  task automatic test_rejects();
    send_tick();
    send_item(FUNC_PULSE, 0, 0, 16'hFFFF, 8'hFF, 1);
    send_item(FUNC_PATTERN, 1, 0, 16'hFFFF, 8'hFF, 1);
    send_item(FUNC_PATTERN, 2, 16'hFFFF, 16'hFFFF, 0, 1);
    send_item(FUNC_STOP, 3, 0, 0, 0, 1);  // idle port, nothing to stop
  endtask

  task automatic test_single_pulse();
    send_item(FUNC_PULSE, 0, 3, 0, 0, 0);
    send_tick();
    send_item(FUNC_PULSE, 0, 1, 0, 0, 0);  // shorter: remaining time wins
    send_item(FUNC_PULSE, 0, 5, 0, 0, 0);  // longer: stretched
    repeat (5) send_tick();
    send_item(FUNC_PULSE, 3, 16'hFFFF, 16'hFFFF, 8'hFF, 1);
    send_item(FUNC_STOP, 3, 0, 0, 0, 0);
  endtask

  task automatic test_patterns();
    send_item(FUNC_PATTERN, 1, 2, 1, 2, 0);
    send_item(FUNC_PATTERN, 2, 1, 0, 3, 1);  // continuous, motor stays on
    repeat (6) send_tick();
    send_item(FUNC_PATTERN, 0, 16'hFFFF, 16'hFFFF, 8'hFF, 1);
    send_item(FUNC_PATTERN, 0, 1, 1, 1, 0);  // restart while motor already on
    send_item(FUNC_STOP, 0, 0, 0, 0, 1);
  endtask

  task automatic test_random_trains(input int n_items);
    int sent;
    int k;
    int p;
    sent = 0;
    while (sent < n_items) begin
      p = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_item(FUNC_PATTERN, p, $urandom_range(1, 4), $urandom_range(0, 3),
                              $urandom_range(1, 4), $urandom_range(0, 1));
        4, 5: send_item(FUNC_PULSE, p, $urandom_range(1, 6), $urandom_range(0, 65535),
                        $urandom_range(0, 255), $urandom_range(0, 1));
        6: send_item(FUNC_STOP, p, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 255), $urandom_range(0, 1));
        7: send_item(func_t'($urandom_range(0, 3)), p, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 1));
        8: begin
          // malformed requests: zero time or zero count
          if ($urandom_range(0, 1))
            send_item(FUNC_PULSE, p, 0, $urandom_range(0, 65535), $urandom_range(0, 255),
                      $urandom_range(0, 1));
          else if ($urandom_range(0, 1))
            send_item(FUNC_PATTERN, p, 0, $urandom_range(0, 65535), $urandom_range(0, 255),
                      $urandom_range(0, 1));
          else
            send_item(FUNC_PATTERN, p, $urandom_range(0, 65535), $urandom_range(0, 65535), 0,
                      $urandom_range(0, 1));
        end
        default: ;
      endcase
      sent++;
      k = $urandom_range(1, 8);
      repeat (k) begin
        send_tick();
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_len = 250;
    steady   = 1;
    test_random_trains(40);
    steady   = 0;
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= FUNC_TICK;
    for (int i = 0; i < NumPorts; i++) begin
      train_active[i] = 1'b0;
      on_stage[i]     = 1'b0;
      motor_run[i]    = 1'b0;
      hard_at_end[i]  = 1'b0;
      phase_left[i]   = '0;
      on_len[i]       = '0;
      off_len[i]      = '0;
      pulses_rem[i]   = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rejects();
    test_single_pulse();
    test_patterns();
    test_random_trains(850);
    test_backpressure();
    calm = 1;
    test_random_trains(180);

    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
